// ----- sv/least_loaded_dispatch_bw_timeline_defines.svh -----
// ----------------------------------------------------------------------------
// least_loaded_dispatch_bw_timeline_defines
// Assertion macros shared by the dispatch block.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_DISPATCH_BW_TIMELINE_DEFINES_SVH
`define LEAST_LOADED_DISPATCH_BW_TIMELINE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LLDBT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define LLDBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/lldbt_pkg.sv -----
// ----------------------------------------------------------------------------
// lldbt_pkg
// Types and constants for the least-loaded dispatch block.
// ----------------------------------------------------------------------------
package lldbt_pkg;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_SLOT_CAPACITY = 2'd0;
   localparam logic [23:0] SLOT_CAPACITY_RESET = 24'd256;

   typedef enum logic {
      OP_DISPATCH = 1'b0,
      OP_SYNC     = 1'b1
   } op_type;

   typedef struct packed {
      logic        operation;
      logic [19:0] compute_cycles;
      logic [23:0] transfer_bytes;
   } req_type;

   typedef struct packed {
      logic [3:0]  chosen_element;
      logic [31:0] start_time;
      logic [31:0] excess_cycles;
      logic [31:0] makespan;
      logic        timeline_overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_READ,
      ST_CALC,
      ST_FINISH,
      ST_RESP
   } state_type;

endpackage

// ----- sv/least_loaded_dispatch_bw_timeline.sv -----
// ----------------------------------------------------------------------------
// least_loaded_dispatch_bw_timeline
// Least-loaded task dispatch over processing elements with a shared
// bandwidth timeline kept in a slot fill memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | lldbt_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall  | lldbt_pkg::rsp_type
//  csr     | in/out    | psel/penable/pready  | slot_capacity at address 0
//
// Dispatch: element scan, prep step, then a read/update loop on the fill
// memory port per timeline slot walked, then the finish and result states.
// Sync: element scan, then finish and result. One item at a time; req_stall
// is high from transfer to result transfer. After reset a clearing pass
// zeroes every fill memory slot with req_stall high.
// ----------------------------------------------------------------------------
`include "least_loaded_dispatch_bw_timeline_defines.svh"

module least_loaded_dispatch_bw_timeline #(
   parameter int unsigned TIMELINE_SLOTS = 4096,
   parameter int unsigned ELEMENT_COUNT  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lldbt_pkg::req_type                  req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lldbt_pkg::rsp_type                  rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lldbt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int unsigned AW = $clog2(TIMELINE_SLOTS);
   localparam int unsigned EW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(TIMELINE_SLOTS - 1);
   localparam logic [EW-1:0] LAST_ELEM = EW'(ELEMENT_COUNT - 1);

   lldbt_pkg::state_type state_ff, state_in;

   logic [23:0]        cap_ff;
   logic [31:0]        busy_ff [ELEMENT_COUNT];
   logic [23:0]        slot_fill_mem [TIMELINE_SLOTS];

   logic               op_ff;
   logic [19:0]        cycles_ff;
   logic [23:0]        bytes_ff;
   logic [EW-1:0]      scan_idx_ff;
   logic [EW-1:0]      pe_ff;
   logic [31:0]        min_ff;
   logic [31:0]        max_ff;
   logic [32:0]        finish_ff;
   logic signed [32:0] rem_ff;
   logic [AW-1:0]      slot_ff;
   logic [AW-1:0]      clr_ff;
   logic [23:0]        rd_fill_ff;
   logic [AW-1:0]      excess_ff;
   logic               ovf_ff;
   lldbt_pkg::rsp_type rsp_ff;

   logic               req_xfer;
   logic               cfg_write;
   logic [31:0]        scan_val;
   logic               fill_below;
   logic signed [32:0] deduct;
   logic signed [32:0] rem_new;
   logic               bytes_done;
   logic [23:0]        final_fill;
   logic [33:0]        excess_diff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [23:0]        mem_wdata;
   logic [33:0]        next_time;
   logic [31:0]        next_sat;
   logic [EW+3:0]      pe_ext;
   logic               start_out;

   assign req_xfer  = req_valid && !req_stall;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lldbt_pkg::SLOT_CAPACITY_RESET;
      end else if (cfg_write && paddr == lldbt_pkg::CSR_ADDR_SLOT_CAPACITY) begin
         cap_ff <= pwdata[23:0];
      end
   end

   always_comb begin
      unique case (paddr)
         lldbt_pkg::CSR_ADDR_SLOT_CAPACITY: prdata = {8'b0, cap_ff};
         default:                           prdata = '0;
      endcase
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lldbt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign scan_val = busy_ff[scan_idx_ff];

   // Shared slot unit: deduct the top-up, and if the bytes run out the slot
   // ends at fill + remaining (top-up and overshoot cancel).
   assign fill_below  = rd_fill_ff < cap_ff;
   assign deduct      = fill_below ? ($signed({9'b0, rd_fill_ff}) - $signed({9'b0, cap_ff}))
                                   : 33'sd0;
   assign rem_new     = rem_ff + deduct;
   assign bytes_done  = rem_new[32] || (rem_new == 33'sd0);
   assign final_fill  = rd_fill_ff + rem_ff[23:0];
   assign excess_diff = {{(34-AW){1'b0}}, slot_ff} - {1'b0, finish_ff};

   assign next_time = {1'b0, finish_ff} + {{(34-AW){1'b0}}, excess_ff};
   assign next_sat  = (next_time[33:32] != 2'b00) ? 32'hFFFF_FFFF : next_time[31:0];

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = '0;
      unique case (state_ff)
         lldbt_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == LAST_SLOT) begin
               state_in = lldbt_pkg::ST_IDLE;
            end
         end
         lldbt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = lldbt_pkg::ST_SCAN;
            end
         end
         lldbt_pkg::ST_SCAN: begin
            if (scan_idx_ff == LAST_ELEM) begin
               state_in = (op_ff == lldbt_pkg::OP_SYNC) ? lldbt_pkg::ST_FINISH
                                                         : lldbt_pkg::ST_PREP;
            end
         end
         lldbt_pkg::ST_PREP: begin
            state_in = (min_ff >= 32'(TIMELINE_SLOTS)) ? lldbt_pkg::ST_FINISH
                                                       : lldbt_pkg::ST_READ;
         end
         lldbt_pkg::ST_READ: begin
            state_in = lldbt_pkg::ST_CALC;
         end
         lldbt_pkg::ST_CALC: begin
            mem_we    = 1'b1;
            mem_wdata = bytes_done ? final_fill : (fill_below ? cap_ff : rd_fill_ff);
            if (bytes_done || slot_ff == LAST_SLOT) begin
               state_in = lldbt_pkg::ST_FINISH;
            end else begin
               state_in = lldbt_pkg::ST_READ;
            end
         end
         lldbt_pkg::ST_FINISH: begin
            state_in = lldbt_pkg::ST_RESP;
         end
         lldbt_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = lldbt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lldbt_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------- fill memory ----------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_fill_mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == lldbt_pkg::ST_READ) begin
         rd_fill_ff <= slot_fill_mem[slot_ff];
      end
   end

   // ---------------- control counters ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         scan_idx_ff <= '0;
      end else begin
         if (state_ff == lldbt_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (req_xfer) begin
            scan_idx_ff <= '0;
         end else if (state_ff == lldbt_pkg::ST_SCAN && scan_idx_ff != LAST_ELEM) begin
            scan_idx_ff <= scan_idx_ff + EW'(1);
         end
      end
   end

   // ---------------- element times ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ELEMENT_COUNT; i++) begin
            busy_ff[i] <= '0;
         end
      end else if (state_ff == lldbt_pkg::ST_FINISH) begin
         if (op_ff == lldbt_pkg::OP_SYNC) begin
            for (int i = 0; i < ELEMENT_COUNT; i++) begin
               busy_ff[i] <= max_ff;
            end
         end else if (!ovf_ff) begin
            busy_ff[pe_ff] <= next_sat;
         end
      end
   end

   // ---------------- datapath ----------------
   assign pe_ext    = {4'b0, pe_ff};
   assign start_out = (op_ff == lldbt_pkg::OP_DISPATCH);

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff     <= req_payload.operation;
         cycles_ff <= req_payload.compute_cycles;
         bytes_ff  <= req_payload.transfer_bytes;
         ovf_ff    <= 1'b0;
         excess_ff <= '0;
      end
      if (state_ff == lldbt_pkg::ST_SCAN) begin
         if (scan_idx_ff == '0) begin
            min_ff <= scan_val;
            max_ff <= scan_val;
            pe_ff  <= '0;
         end else begin
            // strict compare keeps the lowest index on ties
            if (scan_val < min_ff) begin
               min_ff <= scan_val;
               pe_ff  <= scan_idx_ff;
            end
            if (scan_val > max_ff) begin
               max_ff <= scan_val;
            end
         end
      end
      if (state_ff == lldbt_pkg::ST_PREP) begin
         finish_ff <= {1'b0, min_ff} + {13'b0, cycles_ff};
         rem_ff    <= $signed({1'b0, bytes_ff, 8'b0});
         slot_ff   <= min_ff[AW-1:0];
         if (min_ff >= 32'(TIMELINE_SLOTS)) begin
            ovf_ff <= 1'b1;
         end
      end
      if (state_ff == lldbt_pkg::ST_CALC) begin
         rem_ff <= rem_new;
         if (bytes_done) begin
            excess_ff <= excess_diff[33] ? '0 : excess_diff[AW-1:0];
         end else if (slot_ff == LAST_SLOT) begin
            ovf_ff <= 1'b1;
         end else begin
            slot_ff <= slot_ff + AW'(1);
         end
      end
      if (state_ff == lldbt_pkg::ST_FINISH) begin
         rsp_ff.chosen_element    <= start_out ? pe_ext[3:0] : 4'd0;
         rsp_ff.start_time        <= start_out ? min_ff : 32'd0;
         rsp_ff.excess_cycles     <= start_out ? {{(32-AW){1'b0}}, excess_ff} : 32'd0;
         rsp_ff.timeline_overflow <= start_out && ovf_ff;
         if (start_out && !ovf_ff && next_sat > max_ff) begin
            rsp_ff.makespan <= next_sat;
         end else begin
            rsp_ff.makespan <= max_ff;
         end
      end
   end

   assign rsp_payload = rsp_ff;

   // ---------------- assertions ----------------
   `LLDBT_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_xfer, req_stall,
      "input accepted but block not busy next cycle")
   `LLDBT_ASSERT_NOW(a_makespan_covers_start, clock, reset, rsp_valid,
      rsp_payload.makespan >= rsp_payload.start_time, "makespan below start time")
   `LLDBT_ASSERT_NOW(a_overflow_no_excess, clock, reset,
      rsp_valid && rsp_payload.timeline_overflow,
      rsp_payload.excess_cycles == 32'd0, "overflow result carries excess cycles")
   `LLDBT_ASSERT_NOW(a_no_write_past_end, clock, reset, mem_we,
      32'(mem_waddr) < 32'(TIMELINE_SLOTS), "fill memory write past timeline end")

endmodule
